@@ src/xet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xet_pkg
// Shared types, codes and character helpers for the XML event tokenizer.
// ----------------------------------------------------------------------------
package xet_pkg;

  // Event kinds.
  localparam logic [3:0] KIND_TEXT      = 4'd0;
  localparam logic [3:0] KIND_OPEN      = 4'd1;
  localparam logic [3:0] KIND_ATTR      = 4'd2;
  localparam logic [3:0] KIND_CLOSE     = 4'd3;
  localparam logic [3:0] KIND_COMMENT   = 4'd4;
  localparam logic [3:0] KIND_PI        = 4'd5;
  localparam logic [3:0] KIND_CDATA     = 4'd6;
  localparam logic [3:0] KIND_DOC_PART  = 4'd7;
  localparam logic [3:0] KIND_DOC_END   = 4'd8;
  localparam logic [3:0] KIND_DONE      = 4'd9;

  // Error codes carried by the done event.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NO_DOC     = 3'd1;
  localparam logic [2:0] ERR_SYNTAX     = 3'd2;
  localparam logic [2:0] ERR_DEPTH      = 3'd3;
  localparam logic [2:0] ERR_BAD_CLOSE  = 3'd4;

  // Characters of interest.
  localparam logic [15:0] CH_LT    = 16'h003C;
  localparam logic [15:0] CH_GT    = 16'h003E;
  localparam logic [15:0] CH_SLASH = 16'h002F;
  localparam logic [15:0] CH_QMARK = 16'h003F;
  localparam logic [15:0] CH_EXCL  = 16'h0021;
  localparam logic [15:0] CH_DASH  = 16'h002D;
  localparam logic [15:0] CH_EQ    = 16'h003D;
  localparam logic [15:0] CH_SQUOT = 16'h0027;
  localparam logic [15:0] CH_DQUOT = 16'h0022;
  localparam logic [15:0] CH_LBRK  = 16'h005B;
  localparam logic [15:0] CH_RBRK  = 16'h005D;
  localparam logic [15:0] CH_UNDER = 16'h005F;
  localparam logic [15:0] CH_COLON = 16'h003A;
  localparam logic [15:0] CH_DOT   = 16'h002E;
  localparam logic [15:0] CH_UP_D  = 16'h0044;
  localparam logic [15:0] CH_UP_X  = 16'h0058;
  localparam logic [15:0] CH_LO_X  = 16'h0078;
  localparam logic [15:0] CH_UP_M  = 16'h004D;
  localparam logic [15:0] CH_LO_M  = 16'h006D;
  localparam logic [15:0] CH_UP_L  = 16'h004C;
  localparam logic [15:0] CH_LO_L  = 16'h006C;

  // One result event.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] name_start;
    logic [31:0] name_end;
    logic [31:0] data_start;
    logic [31:0] data_end;
    logic        ws_only;
    logic [7:0]  depth;
    logic [2:0]  err;
    logic        last;
  } event_t;

  // Events produced by one character step.
  typedef struct packed {
    logic [1:0] cnt;
    event_t     ev1;
    event_t     ev0;
  } push_t;

  function automatic logic is_sp(input logic [15:0] c);
    return (c == 16'h0020) || (c >= 16'h0009 && c <= 16'h000D);
  endfunction

  function automatic logic is_al(input logic [15:0] c);
    return (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A);
  endfunction

  function automatic logic is_dg(input logic [15:0] c);
    return c >= 16'h0030 && c <= 16'h0039;
  endfunction

  function automatic logic name_first(input logic [15:0] c);
    return is_al(c) || c == CH_UNDER || c == CH_COLON;
  endfunction

  function automatic logic name_next(input logic [15:0] c);
    return name_first(c) || is_dg(c) || c == CH_DASH || c == CH_DOT;
  endfunction

  // Keyword letters, indexed by the match count.
  function automatic logic [15:0] kw_doctype(input logic [2:0] i);
    logic [15:0] c;
    case (i)
      3'd0: c = 16'h0044;
      3'd1: c = 16'h004F;
      3'd2: c = 16'h0043;
      3'd3: c = 16'h0054;
      3'd4: c = 16'h0059;
      3'd5: c = 16'h0050;
      3'd6: c = 16'h0045;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] kw_cdata(input logic [2:0] i);
    logic [15:0] c;
    case (i)
      3'd0: c = 16'h005B;
      3'd1: c = 16'h0043;
      3'd2: c = 16'h0044;
      3'd3: c = 16'h0041;
      3'd4: c = 16'h0054;
      3'd5: c = 16'h0041;
      3'd6: c = 16'h005B;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

@@ src/xet_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xet_core
// Tokenizer state and the combinational step that turns one code unit into
// up to two events.
// ----------------------------------------------------------------------------
module xet_core #(
  parameter int MAX_DEPTH     = 255,
  parameter int POSITION_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step_go,
  input  logic [15:0]    char_code,
  input  logic           is_end,
  output xet_pkg::push_t push
);
  import xet_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int DW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [4:0] {
    S_READY, S_TAG_BEGIN, S_TAG_NAME, S_TAG_INSIDE, S_TAG_END, S_ATTR_NAME,
    S_ATTR_EQ, S_ATTR_QUOTE, S_ATTR_VALUE, S_CLOSE, S_CLOSE_NAME, S_CLOSE_END,
    S_QMARK, S_PI, S_EXCL, S_EXCL_DASH, S_EXCL_DOCTYPE, S_EXCL_CDATA,
    S_COMMENT, S_CDATA, S_DOCTYPE, S_DOCTYPE_TEXT, S_DOCTYPE_ATTR
  } pstate_t;

  typedef enum logic [2:0] {
    E_PLAIN, E_SELF, E_XMLDECL, E_DOCTYPE, E_CDATA
  } ekind_t;

  typedef struct packed {
    pstate_t        ps;
    logic [PB-1:0]  pos;
    logic [PB-1:0]  tm;
    logic [PB-1:0]  tn0;
    logic [PB-1:0]  tn1;
    logic [PB-1:0]  an0;
    logic [PB-1:0]  an1;
    logic [PB-1:0]  dm;
    logic [15:0]    quote;
    ekind_t         ek;
    logic [2:0]     mc;
    logic           tas;
    logic [2:0]     dparts;
    logic [DW-1:0]  dep;
    logic           err;
  } st_t;

  st_t st_r, st_nxt;
  event_t ev_a, ev_b;
  logic [1:0] n_ev;

  // Positions are reported in 32 bits.
  function automatic logic [31:0] p32(input logic [PB-1:0] p);
    logic [63:0] t;
    t = 64'(p);
    return t[31:0];
  endfunction

  function automatic event_t mk_ev(input logic [3:0] kind,
                                   input logic [PB-1:0] ns, input logic [PB-1:0] ne,
                                   input logic [PB-1:0] ds, input logic [PB-1:0] de,
                                   input logic ws, input logic [DW-1:0] dep,
                                   input logic [2:0] err);
    event_t e;
    logic [15:0] d16;
    d16 = 16'(dep);
    e.kind       = kind;
    e.name_start = p32(ns);
    e.name_end   = p32(ne);
    e.data_start = p32(ds);
    e.data_end   = p32(de);
    e.ws_only    = ws;
    e.depth      = d16[7:0];
    e.err        = err;
    e.last       = 1'b0;
    return e;
  endfunction

  // One character step; the inner pass runs again at most once when a name
  // ends and the same unit must be seen by the following state.
  always_comb begin
    st_t         s;
    logic        again;
    logic        fall;
    logic [PB-1:0] p;
    logic [PB-1:0] zp;
    event_t      e;
    logic [15:0] ch;
    s     = st_r;
    ev_a  = '0;
    ev_b  = '0;
    n_ev  = 2'd0;
    again = 1'b0;
    fall  = 1'b0;
    e     = '0;
    ch    = char_code;
    p     = st_r.pos;
    zp    = '0;
    if (!st_r.err) begin
      if (is_end) begin
        if (st_r.pos == zp) e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_NO_DOC);
        else if (s.dep != '0 || s.ps != S_READY)
          e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
        else e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_NONE);
        ev_a  = e;
        n_ev  = 2'd1;
        s.err = 1'b1;
      end else begin
        for (int pass = 0; pass < 2; pass++) begin
          if (pass == 0 || (again && !s.err)) begin
            again = 1'b0;
            e     = '0;
            fall  = 1'b0;
            case (s.ps)
              S_READY: begin
                if (ch == CH_LT) begin
                  if (s.tm != p) begin
                    e = mk_ev(KIND_TEXT, zp, zp, s.tm, p, s.tas, s.dep, ERR_NONE);
                    if (n_ev[0]) ev_b = e; else ev_a = e;
                    n_ev = n_ev + 2'd1;
                  end
                  s.ps = S_TAG_BEGIN;
                end else if (!is_sp(ch)) s.tas = 1'b0;
              end
              S_TAG_BEGIN: begin
                if (name_first(ch)) begin
                  s.tn0 = p;
                  s.ps  = S_TAG_NAME;
                end else if (ch == CH_SLASH) s.ps = S_CLOSE;
                else if (ch == CH_QMARK) begin
                  s.ps = S_QMARK;
                  s.mc = 3'd0;
                end else if (ch == CH_EXCL) s.ps = S_EXCL;
                else if (!is_sp(ch)) fall = 1'b1;
                if (fall) begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_TAG_NAME: begin
                if (!name_next(ch)) begin
                  s.tn1 = p;
                  if (s.dep >= DW'(MAX_DEPTH)) begin
                    e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_DEPTH);
                    if (n_ev[0]) ev_b = e; else ev_a = e;
                    n_ev  = n_ev + 2'd1;
                    s.err = 1'b1;
                  end else begin
                    s.dep = s.dep + DW'(1);
                    s.ek  = E_PLAIN;
                    e = mk_ev(KIND_OPEN, s.tn0, s.tn1, zp, zp, 1'b0, s.dep, ERR_NONE);
                    if (n_ev[0]) ev_b = e; else ev_a = e;
                    n_ev  = n_ev + 2'd1;
                    s.ps  = S_TAG_INSIDE;
                    again = 1'b1;
                  end
                end
              end
              S_TAG_INSIDE: begin
                if (!is_sp(ch)) begin
                  if (is_al(ch) || ch == CH_UNDER) begin
                    s.an0 = p;
                    s.ps  = S_ATTR_NAME;
                  end else if (s.ek == E_PLAIN && ch == CH_SLASH) begin
                    s.ek = E_SELF;
                    s.ps = S_TAG_END;
                  end else if (s.ek == E_PLAIN && ch == CH_GT) begin
                    s.ps  = S_READY;
                    s.tm  = p + PB'(1);
                    s.tas = 1'b1;
                  end else if (s.ek == E_XMLDECL && ch == CH_QMARK) s.ps = S_TAG_END;
                  else begin
                    e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                    if (n_ev[0]) ev_b = e; else ev_a = e;
                    n_ev  = n_ev + 2'd1;
                    s.err = 1'b1;
                  end
                end
              end
              S_TAG_END: begin
                if (ch == CH_GT) begin
                  s.ps  = S_READY;
                  s.tm  = p + PB'(1);
                  s.tas = 1'b1;
                  if (s.ek == E_SELF) fall = 1'b1;
                end
              end
              S_ATTR_NAME: begin
                if (!name_next(ch)) begin
                  s.an1 = p;
                  s.ps  = S_ATTR_EQ;
                  again = 1'b1;
                end
              end
              S_ATTR_EQ: begin
                if (ch == CH_EQ) s.ps = S_ATTR_QUOTE;
                else if (!is_sp(ch)) begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_ATTR_QUOTE: begin
                if (ch == CH_SQUOT || ch == CH_DQUOT) begin
                  s.quote = ch;
                  s.dm    = p + PB'(1);
                  s.ps    = S_ATTR_VALUE;
                end else if (!is_sp(ch)) begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_ATTR_VALUE: begin
                if (ch == s.quote) begin
                  e = mk_ev(KIND_ATTR, s.an0, s.an1, s.dm, p, 1'b0, s.dep, ERR_NONE);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev = n_ev + 2'd1;
                  s.ps = S_TAG_INSIDE;
                end
              end
              S_CLOSE: begin
                if (name_first(ch)) begin
                  s.tn0 = p;
                  s.ps  = S_CLOSE_NAME;
                end else begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_CLOSE_NAME: begin
                if (!name_next(ch)) begin
                  s.tn1 = p;
                  s.ps  = S_CLOSE_END;
                  again = 1'b1;
                end
              end
              S_CLOSE_END: begin
                if (ch == CH_GT) begin
                  s.ps  = S_READY;
                  s.tm  = p + PB'(1);
                  s.tas = 1'b1;
                  fall  = 1'b1;
                end else if (!is_sp(ch)) begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_QMARK: begin
                if (s.mc == 3'd3) begin
                  if (is_sp(ch)) begin
                    s.ek = E_XMLDECL;
                    s.ps = S_TAG_INSIDE;
                  end else fall = 1'b1;
                end else if ((s.mc == 3'd0 && (ch == CH_LO_X || ch == CH_UP_X)) ||
                             (s.mc == 3'd1 && (ch == CH_LO_M || ch == CH_UP_M)) ||
                             (s.mc == 3'd2 && (ch == CH_LO_L || ch == CH_UP_L))) begin
                  s.mc = s.mc + 3'd1;
                end else fall = 1'b1;
                // Not an XML declaration: becomes a PI, re-scanning this unit
                // when some keyword letters were already taken.
                if (fall) begin
                  s.dm = p - PB'(s.mc);
                  s.ps = S_PI;
                  if (s.mc != 3'd0) begin
                    s.mc = 3'd0;
                    if (ch == CH_QMARK) s.mc = 3'd1;
                  end
                end
              end
              S_PI: begin
                if (ch == CH_QMARK) s.mc = 3'd1;
                else if (ch == CH_GT && s.mc == 3'd1) begin
                  e = mk_ev(KIND_PI, zp, zp, s.dm, p - PB'(1), 1'b0, s.dep, ERR_NONE);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.ps  = S_READY;
                  s.tm  = p + PB'(1);
                  s.tas = 1'b1;
                end else s.mc = 3'd0;
              end
              S_EXCL: begin
                if (ch == CH_DASH) s.ps = S_EXCL_DASH;
                else if (ch == CH_UP_D) begin
                  s.ps = S_EXCL_DOCTYPE;
                  s.mc = 3'd1;
                end else if (ch == CH_LBRK) begin
                  s.ps = S_EXCL_CDATA;
                  s.mc = 3'd1;
                end else begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_EXCL_DASH: begin
                if (ch == CH_DASH) begin
                  s.dm = p + PB'(1);
                  s.mc = 3'd0;
                  s.ps = S_COMMENT;
                end else begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_EXCL_DOCTYPE: begin
                if (s.mc == 3'd7) begin
                  if (is_sp(ch)) begin
                    s.ek     = E_DOCTYPE;
                    s.dparts = 3'd0;
                    s.ps     = S_DOCTYPE;
                  end else fall = 1'b1;
                end else if (ch == kw_doctype(s.mc)) s.mc = s.mc + 3'd1;
                else fall = 1'b1;
                if (fall) begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_EXCL_CDATA: begin
                if (s.mc != 3'd7 && ch == kw_cdata(s.mc)) begin
                  s.mc = s.mc + 3'd1;
                  if (s.mc == 3'd7) begin
                    s.ek = E_CDATA;
                    s.dm = p + PB'(1);
                    s.mc = 3'd0;
                    s.ps = S_CDATA;
                  end
                end else begin
                  e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.err = 1'b1;
                end
              end
              S_COMMENT, S_CDATA: begin
                // Terminator scan for "-->" or "]]>".
                if ((s.ps == S_COMMENT && ch == CH_DASH) ||
                    (s.ps == S_CDATA && ch == CH_RBRK)) begin
                  if (s.mc < 3'd2) s.mc = s.mc + 3'd1;
                end else if (ch == CH_GT && s.mc == 3'd2) begin
                  e = mk_ev((s.ps == S_COMMENT) ? KIND_COMMENT : KIND_CDATA, zp, zp,
                            s.dm, p - PB'(2), 1'b0, s.dep, ERR_NONE);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev  = n_ev + 2'd1;
                  s.ps  = S_READY;
                  s.tm  = p + PB'(1);
                  s.tas = 1'b1;
                end else s.mc = 3'd0;
              end
              S_DOCTYPE: begin
                if (!is_sp(ch)) begin
                  if (ch == CH_GT) begin
                    e = mk_ev(KIND_DOC_END, zp, zp, zp, zp, 1'b0, s.dep, ERR_NONE);
                    if (n_ev[0]) ev_b = e; else ev_a = e;
                    n_ev  = n_ev + 2'd1;
                    s.ps  = S_READY;
                    s.tm  = p + PB'(1);
                    s.tas = 1'b1;
                  end else if (s.dparts < 3'd2 && (is_al(ch) || ch == CH_UNDER)) begin
                    s.dm = p;
                    s.ps = S_DOCTYPE_TEXT;
                  end else if (s.dparts >= 3'd2 && s.dparts < 3'd4 && ch == CH_DQUOT) begin
                    s.dm = p + PB'(1);
                    s.ps = S_DOCTYPE_ATTR;
                  end else begin
                    e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                    if (n_ev[0]) ev_b = e; else ev_a = e;
                    n_ev  = n_ev + 2'd1;
                    s.err = 1'b1;
                  end
                end
              end
              S_DOCTYPE_TEXT: begin
                if (!name_next(ch)) begin
                  e = mk_ev(KIND_DOC_PART, zp, zp, s.dm, p, 1'b0, s.dep, ERR_NONE);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev     = n_ev + 2'd1;
                  s.dparts = s.dparts + 3'd1;
                  s.ps     = S_DOCTYPE;
                  again    = 1'b1;
                end
              end
              S_DOCTYPE_ATTR: begin
                if (ch == CH_DQUOT) begin
                  e = mk_ev(KIND_DOC_PART, zp, zp, s.dm, p, 1'b0, s.dep, ERR_NONE);
                  if (n_ev[0]) ev_b = e; else ev_a = e;
                  n_ev     = n_ev + 2'd1;
                  s.dparts = s.dparts + 3'd1;
                  s.ps     = S_DOCTYPE;
                end
              end
              default: begin
                e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_SYNTAX);
                if (n_ev[0]) ev_b = e; else ev_a = e;
                n_ev  = n_ev + 2'd1;
                s.err = 1'b1;
              end
            endcase
            // Element close after "/>" or "</name>".
            if (fall && (s.ps == S_READY)) begin
              if (s.dep == '0) begin
                e = mk_ev(KIND_DONE, zp, zp, zp, zp, 1'b0, s.dep, ERR_BAD_CLOSE);
                s.err = 1'b1;
              end else begin
                s.dep = s.dep - DW'(1);
                e = mk_ev(KIND_CLOSE, s.tn0, s.tn1, zp, zp, 1'b0, s.dep, ERR_NONE);
              end
              if (n_ev[0]) ev_b = e; else ev_a = e;
              n_ev = n_ev + 2'd1;
            end
          end
        end
        s.pos = p + PB'(1);
      end
    end
    // Mark the last event of this step.
    if (n_ev == 2'd2) ev_b.last = 1'b1;
    else if (n_ev == 2'd1) ev_a.last = 1'b1;
    st_nxt = s;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      st_r.ps    <= S_READY;
      st_r.ek    <= E_PLAIN;
      st_r.tas   <= 1'b1;
    end else if (step_go) begin
      st_r <= st_nxt;
    end
  end

  assign push.cnt = step_go ? n_ev : 2'd0;
  assign push.ev0 = ev_a;
  assign push.ev1 = ev_b;

endmodule

@@ src/xet_out_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xet_out_fifo
// Four-entry result queue that takes up to two events a cycle and hands out
// one.
// ----------------------------------------------------------------------------
module xet_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  xet_pkg::push_t  push,
  input  logic            pop,
  output logic [2:0]      count,
  output xet_pkg::event_t head
);
  import xet_pkg::*;

  event_t     mem_r [4];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r + push.cnt;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_r] <= push.ev0;
    if (push.cnt == 2'd2) mem_r[wr_r + 2'd1] <= push.ev1;
  end

  assign count = cnt_r;
  assign head  = mem_r[rd_r];

endmodule

@@ src/xml_event_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_event_tokenizer
// Streaming XML tokenizer: one UTF-16 code unit per input transaction,
// SAX-style events with position spans out.
// ----------------------------------------------------------------------------
// Each accepted code unit is held in an input register until it is stepped,
// and the whole tokenizer step is done combinationally on it, writing zero,
// one or two events into a four-entry result queue. A unit is taken every
// cycle while the queue has room for two events, so the input runs at one
// unit per clock as long as results are drained at least as fast as they are
// made; a unit's two events leave one at a time. Events leave with the kind
// on out_tuser and the last event of each input unit flagged on out_tlast.
// After a done event the block reports nothing further until reset.
module xml_event_tokenizer #(
  parameter int MAX_DEPTH     = 255,
  parameter int POSITION_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // char_code
  input  logic         in_tlast,   // is_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // name_start, name_end, data_start, data_end,
                                   // whitespace_only, nesting_depth, error_code, 0 pad
  output logic [3:0]   out_tuser,  // event_kind
  output logic         out_tlast   // last_of_run
);
  import xet_pkg::*;

  logic        in_vld_r;
  logic [15:0] in_char_r;
  logic        in_end_r;
  logic        step_go;
  logic [2:0]  q_count;
  push_t       push;
  event_t      head;

  // A step fires when the queue can take two more events.
  assign step_go   = in_vld_r && (q_count <= 3'd2);
  assign in_tready = !in_vld_r || step_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  xet_core #(
    .MAX_DEPTH    (MAX_DEPTH),
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_go  (step_go),
    .char_code(in_char_r),
    .is_end   (in_end_r),
    .push     (push)
  );

  xet_out_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (out_tvalid && out_tready),
    .count(q_count),
    .head (head)
  );

  // Result channel.
  assign out_tvalid = (q_count != 3'd0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {4'd0, head.err, head.depth, head.ws_only, head.data_end,
                       head.data_start, head.name_end, head.name_start};

  // The queue never holds more than four events.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 3'd4) else $error("result queue overfilled");

  // A step never pushes more than the free space.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, q_count} + {2'b00, push.cnt}) <= 4'd4) else $error("push overflow");

  // A done event always closes the run of its input unit.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_DONE) |-> out_tlast)
    else $error("done event not last");

endmodule

@@ tb/xml_event_tokenizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_event_tokenizer_tb
// Streams a generated XML document into the tokenizer and checks every event
// against a behavioural model of the tokenizer kept in this bench.
// ----------------------------------------------------------------------------
// The document opens with a short hand-written prolog: an XML declaration,
// a DOCTYPE, comments, CDATA, PIs and extreme text units. It continues with
// randomly nested elements, attributes and character data, and closes with
// one randomly chosen ending: a clean end, an unclosed element, a stray close
// tag or a depth overflow. Both sides idle in random bursts, the receiver
// holds off once for a long stretch, and the sender pauses once until the
// event queue has drained.
module xml_event_tokenizer_tb;
  import xet_pkg::*;

  localparam int DEPTH_LIMIT = 255;

  typedef enum logic [4:0] {
    P_READY, P_TAG_BEGIN, P_TAG_NAME, P_TAG_INSIDE, P_TAG_END, P_ATTR_NAME,
    P_ATTR_EQ, P_ATTR_QUOTE, P_ATTR_VALUE, P_CLOSE, P_CLOSE_NAME, P_CLOSE_END,
    P_QMARK, P_PI, P_EXCL, P_EXCL_DASH, P_EXCL_DOCTYPE, P_EXCL_CDATA,
    P_COMMENT, P_CDATA, P_DOCTYPE, P_DOCTYPE_TEXT, P_DOCTYPE_ATTR
  } tok_state_t;

  typedef enum logic [2:0] {EL_PLAIN, EL_SELF, EL_XMLDECL, EL_DOCTYPE, EL_CDATA} elem_kind_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [143:0] out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;

  xml_event_tokenizer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Document units waiting to be sent: bit 16 marks the end of the document.
  logic [16:0] doc_units[$];
  event_t      expected_events[$];
  event_t      unit_events[$];
  int          total_units;
  int          units_sent;
  int          events_seen;
  int          errors;
  int          gen_depth;

  // Tokenizer model state.
  tok_state_t  tk_state;
  logic [31:0] tk_pos, tk_text_mark, tk_tag_ns, tk_tag_ne, tk_attr_ns, tk_attr_ne;
  logic [31:0] tk_data_mark;
  logic [15:0] tk_quote;
  elem_kind_t  tk_elem;
  logic [2:0]  tk_match;
  logic        tk_all_space;
  logic [2:0]  tk_parts;
  logic [7:0]  tk_depth;
  logic        tk_stopped;

  // Handshake bookkeeping; in_fired is written at posedge and read at negedge.
  logic        in_fired;
  int          in_gap;
  bit          pause_done;
  int          pause_at;
  int          out_gap;
  bit          hold_done;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------
  function automatic bit c_space(logic [15:0] c);
    return c == 16'd32 || (c >= 16'd9 && c <= 16'd13);
  endfunction

  function automatic bit c_alpha(logic [15:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit c_name0(logic [15:0] c);
    return c_alpha(c) || c == "_" || c == ":";
  endfunction

  function automatic bit c_name1(logic [15:0] c);
    return c_name0(c) || (c >= "0" && c <= "9") || c == "-" || c == ".";
  endfunction

  // --------------------------------------------------------------------------
  // Tokenizer model
  // --------------------------------------------------------------------------
  task automatic emit(logic [3:0] k, logic [31:0] ns, logic [31:0] ne, logic [31:0] ds,
                      logic [31:0] de, logic ws, logic [2:0] code);
    event_t e;
    e = '0;
    e.kind = k;
    e.name_start = ns;
    e.name_end = ne;
    e.data_start = ds;
    e.data_end = de;
    e.ws_only = ws;
    e.depth = tk_depth;
    e.err = code;
    if (unit_events.size() < 2) unit_events.push_back(e);
  endtask

  task automatic stop_with(logic [2:0] code);
    emit(KIND_DONE, 0, 0, 0, 0, 1'b0, code);
    tk_stopped = 1'b1;
  endtask

  task automatic back_to_text(logic [31:0] p);
    tk_state = P_READY;
    tk_text_mark = p + 1;
    tk_all_space = 1'b1;
  endtask

  task automatic close_element();
    if (tk_depth == 0) begin
      stop_with(ERR_BAD_CLOSE);
    end else begin
      tk_depth = tk_depth - 1;
      emit(KIND_CLOSE, tk_tag_ns, tk_tag_ne, 0, 0, 1'b0, ERR_NONE);
    end
  endtask

  task automatic finish_tag(logic [31:0] p);
    back_to_text(p);
    if (tk_elem == EL_SELF) close_element();
  endtask

  // Looks for "?>" ending a processing instruction.
  task automatic scan_pi_end(logic [15:0] c, logic [31:0] p);
    if (c == "?") begin
      tk_match = 1;
    end else if (c == ">" && tk_match == 1) begin
      emit(KIND_PI, 0, 0, tk_data_mark, p - 1, 1'b0, ERR_NONE);
      back_to_text(p);
    end else begin
      tk_match = 0;
    end
  endtask

  // Looks for "-->" or "]]>": two of the repeat unit, then '>'.
  task automatic scan_block_end(logic [15:0] c, logic [31:0] p, logic [15:0] rep,
                                logic [3:0] k);
    if (c == rep) begin
      if (tk_match < 2) tk_match = tk_match + 1;
    end else if (c == ">" && tk_match == 2) begin
      emit(k, 0, 0, tk_data_mark, p - 2, 1'b0, ERR_NONE);
      back_to_text(p);
    end else begin
      tk_match = 0;
    end
  endtask

  task automatic tokenizer_reset();
    tk_state = P_READY;
    tk_pos = 0;
    tk_text_mark = 0;
    tk_tag_ns = 0;
    tk_tag_ne = 0;
    tk_attr_ns = 0;
    tk_attr_ne = 0;
    tk_data_mark = 0;
    tk_quote = 0;
    tk_elem = EL_PLAIN;
    tk_match = 0;
    tk_all_space = 1'b1;
    tk_parts = 0;
    tk_depth = 0;
    tk_stopped = 1'b0;
  endtask

  // Advances the model by one document unit and queues the events it causes.
  task automatic tokenize_unit(logic [15:0] c, logic fin);
    string       kw_doc;
    string       kw_cd;
    logic [31:0] p;
    bit          again;
    bit          taken;
    event_t      e;
    kw_doc = "DOCTYPE";
    kw_cd = "[CDATA[";
    p = tk_pos;
    unit_events.delete();
    if (tk_stopped) return;
    if (fin) begin
      if (tk_pos == 0) stop_with(ERR_NO_DOC);
      else if (tk_depth > 0 || tk_state != P_READY) stop_with(ERR_SYNTAX);
      else stop_with(ERR_NONE);
    end else begin
      do begin
        again = 1'b0;
        case (tk_state)
          P_READY: begin
            if (c == "<") begin
              if (tk_text_mark != p)
                emit(KIND_TEXT, 0, 0, tk_text_mark, p, tk_all_space, ERR_NONE);
              tk_state = P_TAG_BEGIN;
            end else if (!c_space(c)) begin
              tk_all_space = 1'b0;
            end
          end
          P_TAG_BEGIN: begin
            if (c_name0(c)) begin
              tk_tag_ns = p;
              tk_state = P_TAG_NAME;
            end else if (c == "/") tk_state = P_CLOSE;
            else if (c == "?") begin
              tk_state = P_QMARK;
              tk_match = 0;
            end else if (c == "!") tk_state = P_EXCL;
            else if (!c_space(c)) stop_with(ERR_SYNTAX);
          end
          P_TAG_NAME: begin
            if (!c_name1(c)) begin
              tk_tag_ne = p;
              if (tk_depth >= DEPTH_LIMIT) begin
                stop_with(ERR_DEPTH);
              end else begin
                tk_depth = tk_depth + 1;
                tk_elem = EL_PLAIN;
                emit(KIND_OPEN, tk_tag_ns, tk_tag_ne, 0, 0, 1'b0, ERR_NONE);
                tk_state = P_TAG_INSIDE;
                again = 1'b1;
              end
            end
          end
          P_TAG_INSIDE: begin
            if (!c_space(c)) begin
              if (c_alpha(c) || c == "_") begin
                tk_attr_ns = p;
                tk_state = P_ATTR_NAME;
              end else if (tk_elem == EL_PLAIN && c == "/") begin
                tk_elem = EL_SELF;
                tk_state = P_TAG_END;
              end else if (tk_elem == EL_PLAIN && c == ">") finish_tag(p);
              else if (tk_elem == EL_XMLDECL && c == "?") tk_state = P_TAG_END;
              else stop_with(ERR_SYNTAX);
            end
          end
          P_TAG_END: begin
            if (c == ">") finish_tag(p);
          end
          P_ATTR_NAME: begin
            if (!c_name1(c)) begin
              tk_attr_ne = p;
              tk_state = P_ATTR_EQ;
              again = 1'b1;
            end
          end
          P_ATTR_EQ: begin
            if (c == "=") tk_state = P_ATTR_QUOTE;
            else if (!c_space(c)) stop_with(ERR_SYNTAX);
          end
          P_ATTR_QUOTE: begin
            if (c == "'" || c == "\"") begin
              tk_quote = c;
              tk_data_mark = p + 1;
              tk_state = P_ATTR_VALUE;
            end else if (!c_space(c)) stop_with(ERR_SYNTAX);
          end
          P_ATTR_VALUE: begin
            if (c == tk_quote) begin
              emit(KIND_ATTR, tk_attr_ns, tk_attr_ne, tk_data_mark, p, 1'b0, ERR_NONE);
              tk_state = P_TAG_INSIDE;
            end
          end
          P_CLOSE: begin
            if (c_name0(c)) begin
              tk_tag_ns = p;
              tk_state = P_CLOSE_NAME;
            end else stop_with(ERR_SYNTAX);
          end
          P_CLOSE_NAME: begin
            if (!c_name1(c)) begin
              tk_tag_ne = p;
              tk_state = P_CLOSE_END;
              again = 1'b1;
            end
          end
          P_CLOSE_END: begin
            if (c == ">") begin
              back_to_text(p);
              close_element();
            end else if (!c_space(c)) stop_with(ERR_SYNTAX);
          end
          P_QMARK: begin
            // Matching "xml" in any case; a space after it makes a declaration.
            taken = 1'b0;
            if (tk_match == 3) begin
              if (c_space(c)) begin
                tk_elem = EL_XMLDECL;
                tk_state = P_TAG_INSIDE;
                taken = 1'b1;
              end
            end else if ((tk_match == 0 && (c == "x" || c == "X")) ||
                         (tk_match == 1 && (c == "m" || c == "M")) ||
                         (tk_match == 2 && (c == "l" || c == "L"))) begin
              tk_match = tk_match + 1;
              taken = 1'b1;
            end
            if (!taken) begin
              tk_data_mark = p - tk_match;
              tk_state = P_PI;
              if (tk_match != 0) begin
                tk_match = 0;
                scan_pi_end(c, p);
              end
            end
          end
          P_PI: scan_pi_end(c, p);
          P_EXCL: begin
            if (c == "-") tk_state = P_EXCL_DASH;
            else if (c == "D") begin
              tk_state = P_EXCL_DOCTYPE;
              tk_match = 1;
            end else if (c == "[") begin
              tk_state = P_EXCL_CDATA;
              tk_match = 1;
            end else stop_with(ERR_SYNTAX);
          end
          P_EXCL_DASH: begin
            if (c == "-") begin
              tk_data_mark = p + 1;
              tk_match = 0;
              tk_state = P_COMMENT;
            end else stop_with(ERR_SYNTAX);
          end
          P_EXCL_DOCTYPE: begin
            if (tk_match >= 7) begin
              if (c_space(c)) begin
                tk_elem = EL_DOCTYPE;
                tk_parts = 0;
                tk_state = P_DOCTYPE;
              end else stop_with(ERR_SYNTAX);
            end else if (c == 16'(kw_doc[tk_match])) tk_match = tk_match + 1;
            else stop_with(ERR_SYNTAX);
          end
          P_EXCL_CDATA: begin
            if (tk_match < 7 && c == 16'(kw_cd[tk_match])) begin
              tk_match = tk_match + 1;
              if (tk_match == 7) begin
                tk_elem = EL_CDATA;
                tk_data_mark = p + 1;
                tk_match = 0;
                tk_state = P_CDATA;
              end
            end else stop_with(ERR_SYNTAX);
          end
          P_COMMENT: scan_block_end(c, p, "-", KIND_COMMENT);
          P_CDATA: scan_block_end(c, p, "]", KIND_CDATA);
          P_DOCTYPE: begin
            if (!c_space(c)) begin
              if (c == ">") begin
                emit(KIND_DOC_END, 0, 0, 0, 0, 1'b0, ERR_NONE);
                back_to_text(p);
              end else if (tk_parts < 2 && (c_alpha(c) || c == "_")) begin
                tk_data_mark = p;
                tk_state = P_DOCTYPE_TEXT;
              end else if (tk_parts >= 2 && tk_parts < 4 && c == "\"") begin
                tk_data_mark = p + 1;
                tk_state = P_DOCTYPE_ATTR;
              end else stop_with(ERR_SYNTAX);
            end
          end
          P_DOCTYPE_TEXT: begin
            if (!c_name1(c)) begin
              emit(KIND_DOC_PART, 0, 0, tk_data_mark, p, 1'b0, ERR_NONE);
              tk_parts = tk_parts + 1;
              tk_state = P_DOCTYPE;
              again = 1'b1;
            end
          end
          P_DOCTYPE_ATTR: begin
            if (c == "\"") begin
              emit(KIND_DOC_PART, 0, 0, tk_data_mark, p, 1'b0, ERR_NONE);
              tk_parts = tk_parts + 1;
              tk_state = P_DOCTYPE;
            end
          end
          default: stop_with(ERR_SYNTAX);
        endcase
      end while (again && !tk_stopped);
      tk_pos = p + 1;
    end
    // The last event of the unit carries the run marker.
    for (int i = 0; i < unit_events.size(); i++) begin
      e = unit_events[i];
      e.last = (i == unit_events.size() - 1);
      expected_events.push_back(e);
    end
  endtask

  // --------------------------------------------------------------------------
  // Document generation
  // --------------------------------------------------------------------------
  task automatic put_unit(logic [15:0] c);
    doc_units.push_back({1'b0, c});
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put_unit(16'(s[i]));
  endtask

  task automatic put_name();
    int n;
    n = $urandom_range(1, 4);
    put_unit(16'($urandom_range(0, 1) ? $urandom_range("a", "z") : $urandom_range("A", "Z")));
    for (int i = 1; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: put_unit(16'($urandom_range("0", "9")));
        1: put_unit("-");
        2: put_unit("_");
        default: put_unit(16'($urandom_range("a", "z")));
      endcase
    end
  endtask

  // Random unit that is none of the listed terminator characters.
  function automatic logic [15:0] body_unit(logic [15:0] bad0, logic [15:0] bad1);
    logic [15:0] c;
    case ($urandom_range(0, 3))
      0: c = 16'($urandom);
      1: c = " ";
      default: c = 16'($urandom_range(33, 126));
    endcase
    if (c == bad0 || c == bad1) c = "a";
    return c;
  endfunction

  task automatic put_body(int n, logic [15:0] bad0, logic [15:0] bad1);
    for (int i = 0; i < n; i++) put_unit(body_unit(bad0, bad1));
  endtask

  task automatic put_text();
    int n;
    n = $urandom_range(1, 8);
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < n; i++) put_unit(16'($urandom_range(0, 1) ? 32 : $urandom_range(9, 13)));
    end else begin
      put_body(n, "<", "<");
    end
  endtask

  task automatic put_open();
    int na;
    logic [15:0] q;
    put_unit("<");
    put_name();
    na = $urandom_range(0, 2);
    for (int i = 0; i < na; i++) begin
      put_unit(" ");
      put_name();
      if ($urandom_range(0, 3) == 0) put_unit(" ");
      put_unit("=");
      q = $urandom_range(0, 1) ? 16'("'") : 16'("\"");
      put_unit(q);
      put_body($urandom_range(0, 5), q, q);
      put_unit(q);
    end
    case ($urandom_range(0, 5))
      0: put_str("/>");
      1: put_str("/ j>");
      default: begin
        put_unit(">");
        gen_depth++;
      end
    endcase
  endtask

  task automatic put_close();
    put_str("</");
    put_name();
    if ($urandom_range(0, 3) == 0) put_unit(" ");
    put_unit(">");
    gen_depth--;
  endtask

  task automatic put_doctype();
    int names;
    int quoted;
    put_str("<!DOCTYPE ");
    names = $urandom_range(0, 2);
    quoted = (names == 2) ? $urandom_range(0, 2) : 0;
    for (int i = 0; i < names; i++) begin
      put_name();
      put_unit(" ");
    end
    for (int i = 0; i < quoted; i++) begin
      put_unit("\"");
      put_body($urandom_range(0, 4), "\"", "\"");
      put_str("\" ");
    end
    put_unit(">");
  endtask

  task automatic build_document();
    int ending;
    int body_len;
    // The ending is chosen first so that a long depth-overflow tail shortens
    // the random body and the document keeps roughly the same length.
    ending = $urandom_range(0, 4);
    body_len = (ending == 2) ? 1540 - 3 * (DEPTH_LIMIT + 1) : 1540;
    // Hand-written prolog: declaration with junk after '?', DOCTYPE with all
    // four parts, empty and short comment, CDATA and PIs, extreme text units.
    put_str("<?XmL version='1.0' x=\"\"?zz>");
    put_str("<!DOCTYPE root sys \"a b\" \"\">");
    put_str("<!----><!-- c - d --><![CDATA[]]><![CDATA[ ]x] ]]>");
    put_str("<?x?><?pi data?><?xm ?>");
    put_str("<r>");
    put_unit(16'hFFFF);
    put_unit(16'h0000);
    put_unit(16'h8000);
    put_str(" <e_1 a='>' b=\"x\"/>\t</r>");
    gen_depth = 0;
    // Random nested content.
    while (doc_units.size() < body_len) begin
      case ($urandom_range(0, 11))
        0, 1, 2: if (gen_depth < 6) put_open();
        3, 4: if (gen_depth > 0) put_close();
        5, 6: put_text();
        7: begin
          put_str("<!--");
          put_body($urandom_range(0, 6), "-", ">");
          put_str("-->");
        end
        8: begin
          put_str("<![CDATA[");
          put_body($urandom_range(0, 6), "]", ">");
          put_str("]]>");
        end
        9: begin
          put_str("<?p");
          put_body($urandom_range(0, 6), "?", "?");
          put_str("?>");
        end
        10: put_doctype();
        default: if ($urandom_range(0, 7) == 0 && gen_depth == 0) put_str("<?xml a='1'?>");
      endcase
    end
    // One way of ending the document.
    case (ending)
      0: ;  // elements left open
      1: begin
        while (gen_depth > 0) put_close();
        put_str("</z>");
      end
      2: begin
        while (gen_depth > 0) put_close();
        for (int i = 0; i <= DEPTH_LIMIT; i++) put_str("<a>");
      end
      default: while (gen_depth > 0) put_close();
    endcase
    doc_units.push_back({1'b1, 16'($urandom)});
    // A unit sent after the end marker is still accepted but yields no event.
    doc_units.push_back({1'b0, 16'("<")});
  endtask

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fired) begin
      in_tvalid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (units_sent == pause_at && !pause_done) begin
      // Sender waits until every expected event has come out.
      if (expected_events.size() == 0) pause_done = 1'b1;
      in_tvalid <= 1'b0;
    end else if (doc_units.size() == 0) begin
      in_tvalid <= 1'b0;
    end else if (units_sent < total_units * 4 / 5 && $urandom_range(0, 15) == 0) begin
      in_gap = $urandom_range(0, 17);
      in_tvalid <= 1'b0;
    end else begin
      in_tvalid <= 1'b1;
      in_tdata <= doc_units[0][15:0];
      in_tlast <= doc_units[0][16];
    end
  end

  // --------------------------------------------------------------------------
  // Output ready driver
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else if (!hold_done && events_seen >= 40) begin
      // One long hold-off so that the block fills and stalls its input.
      hold_done = 1'b1;
      out_gap = 300;
      out_tready <= 1'b0;
    end else if (units_sent < total_units * 4 / 5 && $urandom_range(0, 11) == 0) begin
      out_gap = $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Input and output monitors
  // --------------------------------------------------------------------------
  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: event %0d %s mismatch: expected %0h, actual %0h",
               $time, events_seen, fname, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    in_fired = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      in_fired = 1'b1;
      tokenize_unit(in_tdata, in_tlast);
      void'(doc_units.pop_front());
      units_sent++;
    end
  end

  always @(posedge clk) begin
    event_t exp_e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected event: kind %0d, tdata %0h", $time, out_tuser, out_tdata);
        errors++;
      end else begin
        exp_e = expected_events.pop_front();
        check_field("event_kind", exp_e.kind, out_tuser);
        check_field("name_start", exp_e.name_start, out_tdata[31:0]);
        check_field("name_end", exp_e.name_end, out_tdata[63:32]);
        check_field("data_start", exp_e.data_start, out_tdata[95:64]);
        check_field("data_end", exp_e.data_end, out_tdata[127:96]);
        check_field("whitespace_only", exp_e.ws_only, out_tdata[128]);
        check_field("nesting_depth", exp_e.depth, out_tdata[136:129]);
        check_field("error_code", exp_e.err, out_tdata[139:137]);
        check_field("last_of_run", exp_e.last, out_tlast);
      end
      events_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    in_fired = 1'b0;
    in_gap = 0;
    out_gap = 0;
    pause_done = 1'b0;
    hold_done = 1'b0;
    units_sent = 0;
    events_seen = 0;
    errors = 0;
    tokenizer_reset();
    build_document();
    total_units = doc_units.size();
    pause_at = $urandom_range(200, 900);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (doc_units.size() == 0);
    wait (expected_events.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("PASS xml_event_tokenizer");
    end else begin
      $display("FAIL xml_event_tokenizer");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("FAIL xml_event_tokenizer");
    $finish;
  end

endmodule
